// ===== hw/rtl/stu_pkg.sv =====
// ============================================================================
// stu_pkg
// Shared types and constants of the two-gate speed trap.
// ============================================================================
`default_nettype none

package stu_pkg;

    localparam int TIME_W  = 32;
    localparam int DIST_W  = 16;
    localparam int SPEED_W = 26;
    localparam int NUM_W   = 30;   // distance * 9216 fits in 30 bits
    localparam int DEN_W   = 36;   // elapsed * 10 fits in 36 bits
    localparam int STEP_W  = 5;    // counts the 30 quotient bits

    localparam logic [DIST_W-1:0] DIST_RESET = 16'd1000;
    localparam logic [STEP_W-1:0] LAST_STEP  = 5'(NUM_W - 1);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RANGE_ERR = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              first_gate_edge;
        logic              second_gate_edge;
    } in_item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_q8;
        logic               status;
        logic [TIME_W-1:0]  event_number;
        logic [TIME_W-1:0]  elapsed_ms;
    } out_item_t;

    // One measurement request between the front and the back.
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic              status;
        logic [TIME_W-1:0] event_number;
        logic [TIME_W-1:0] elapsed_ms;
    } meas_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stu_front.sv =====
// ============================================================================
// stu_front
// Gate edge handling: arming, time latch, event count and request build.
// ============================================================================
`default_nettype none

module stu_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    input  wire stu_pkg::in_item_t            item,
    input  wire logic                         cfg_we,
    input  wire logic [stu_pkg::DIST_W-1:0]   cfg_data,
    output logic                              meas_valid,
    output stu_pkg::meas_t                    meas
);

    logic                        armed_reg, armed_next;
    logic [stu_pkg::TIME_W-1:0]  first_time_reg, first_time_next;
    logic [stu_pkg::TIME_W-1:0]  count_reg, count_next;
    logic [stu_pkg::DIST_W-1:0]  dist_reg;
    logic                        armed_eff;
    logic                        fire;
    logic                        zero_dt;
    logic [stu_pkg::TIME_W-1:0]  start_time;
    logic [stu_pkg::TIME_W-1:0]  dt;

    always_comb
    begin
        // The first edge is handled before the second one of the same item.
        start_time = (item.first_gate_edge && !armed_reg) ? item.now_ms : first_time_reg;
        armed_eff  = armed_reg || item.first_gate_edge;
        fire       = item_valid && item.second_gate_edge && armed_eff;
        dt         = item.now_ms - start_time;
        zero_dt    = (dt == '0);

        armed_next      = armed_reg;
        first_time_next = first_time_reg;
        count_next      = count_reg;
        if (item_valid)
        begin
            armed_next      = armed_eff && !fire;
            first_time_next = start_time;
            if (fire && !zero_dt)
            begin
                count_next = count_reg + 32'd1;
            end
        end

        meas_valid        = fire;
        meas.num          = ({14'd0, dist_reg} << 13) + ({14'd0, dist_reg} << 10);
        meas.den          = ({4'd0, dt} << 3) + ({4'd0, dt} << 1);
        meas.status       = zero_dt ? stu_pkg::STATUS_RANGE_ERR : stu_pkg::STATUS_OK;
        meas.event_number = count_next;
        meas.elapsed_ms   = dt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            first_time_reg <= '0;
            count_reg      <= '0;
            dist_reg       <= stu_pkg::DIST_RESET;
        end
        else
        begin
            armed_reg      <= armed_next;
            first_time_reg <= first_time_next;
            count_reg      <= count_next;
            if (cfg_we)
            begin
                dist_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stu_queue.sv =====
// ============================================================================
// stu_queue
// Two-entry request queue between the front and the back.
// ============================================================================
`default_nettype none

module stu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire stu_pkg::meas_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output logic                empty,
    output stu_pkg::meas_t      rd_data
);

    logic [1:0]     count_reg, count_next;
    stu_pkg::meas_t head_reg;
    stu_pkg::meas_t tail_reg;
    logic           do_wr;
    logic           do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = head_reg;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_rd)
        begin
            if (do_wr && (count_reg == 2'd1))
            begin
                head_reg <= wr_data;
            end
            else
            begin
                head_reg <= tail_reg;
            end
            if (do_wr && (count_reg == 2'd2))
            begin
                tail_reg <= wr_data;
            end
        end
        else if (do_wr)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= wr_data;
            end
            else
            begin
                tail_reg <= wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stu_back.sv =====
// ============================================================================
// stu_back
// Serial restoring divider for the speed and the result register.
// ============================================================================
`default_nettype none

module stu_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire stu_pkg::meas_t q_data,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output stu_pkg::out_item_t  result
);

    stu_pkg::back_state_t         state_reg, state_next;
    logic [stu_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [stu_pkg::DEN_W-1:0]    rem_reg, rem_next;
    logic [stu_pkg::NUM_W-1:0]    quo_reg, quo_next;
    stu_pkg::meas_t               job_reg, job_next;
    logic                         out_valid_reg, out_valid_next;
    stu_pkg::out_item_t           out_reg, out_next;
    logic [stu_pkg::DEN_W:0]      rem_shift;
    logic [stu_pkg::DEN_W:0]      rem_diff;
    logic                         slot_free;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign slot_free = !out_valid_reg || pop;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[stu_pkg::NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, job_reg.den};

        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            stu_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    quo_next   = q_data.num;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = stu_pkg::BK_DIV;
                end
            end
            stu_pkg::BK_DIV:
            begin
                // One quotient bit per cycle; the numerator shifts out of quo.
                if (!rem_diff[stu_pkg::DEN_W])
                begin
                    rem_next = rem_diff[stu_pkg::DEN_W-1:0];
                    quo_next = {quo_reg[stu_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[stu_pkg::DEN_W-1:0];
                    quo_next = {quo_reg[stu_pkg::NUM_W-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == stu_pkg::LAST_STEP)
                begin
                    state_next = stu_pkg::BK_DONE;
                end
            end
            stu_pkg::BK_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.speed_q8     = (job_reg.status == stu_pkg::STATUS_RANGE_ERR)
                                            ? '0 : quo_reg[stu_pkg::SPEED_W-1:0];
                    out_next.status       = job_reg.status;
                    out_next.event_number = job_reg.event_number;
                    out_next.elapsed_ms   = job_reg.elapsed_ms;
                    state_next            = stu_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = stu_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stu_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        job_reg  <= job_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/two_gate_speed_trap_unit.sv =====
// ============================================================================
// two_gate_speed_trap_unit
// Time-of-flight speed measurement between two light gates.
// ============================================================================
//
//  Channel   Handshake             Payload
//  --------  --------------------  ---------------------------------------
//  item      push / full           now_ms, first_gate_edge, second_gate_edge
//  result    pop / empty           speed_q8, status, event_number, elapsed_ms
//  cfg       cfg_valid / cfg_ready cfg_data = gate_distance_mm
//
// An item is taken when push is high and full is low; a measurement request
// then leaves the queue, passes through the serial divider (one quotient
// bit per cycle) and reaches the result register in the back end.
// Reset is asynchronous and active low; the distance returns to 1000 mm.
// Up to two requests wait in the queue, so items keep flowing while the
// divider runs; full rises only when the queue holds two requests.
// A result that is not popped holds the divider in its final state.
//
`default_nettype none

module two_gate_speed_trap_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire stu_pkg::in_item_t           item,
    output logic                             empty,
    input  wire logic                        pop,
    output stu_pkg::out_item_t               result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [stu_pkg::DIST_W-1:0]  cfg_data
);

    logic           item_take;
    logic           meas_valid;
    stu_pkg::meas_t meas;
    logic           q_empty;
    logic           q_pop;
    stu_pkg::meas_t q_data;

    // The distance register is always writable.
    assign cfg_ready = 1'b1;

    // The front accepts only when the queue has room for a possible request.
    assign item_take = push && !full;

    stu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_take),
        .item       (item),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .meas_valid (meas_valid),
        .meas       (meas)
    );

    stu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (meas_valid),
        .wr_data (meas),
        .full    (full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    stu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/stu_checker.sv =====
// ============================================================================
// stu_checker
// Port-level checks of the speed trap's result channel.
// ============================================================================
`default_nettype none

module stu_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire stu_pkg::out_item_t result
);

    // A waiting result must not change until it is popped.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // A range error always reports zero speed.
    a_error_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status) |-> (result.speed_q8 == '0))
        else $error("range error with nonzero speed");

    // The status flags exactly the zero elapsed time.
    a_status_dt: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status == (result.elapsed_ms == '0)))
        else $error("status does not match elapsed time");

    // Once reset has been seen at an edge, no result is offered at the next one.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result offered during reset");

endmodule

bind two_gate_speed_trap_unit stu_checker u_stu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// ===== tb/sv/speed_trap_compare.sv =====
`timescale 1ns / 100ps
// ============================================================================
// speed_trap_compare
// Watches the gate, result and distance channels of the speed trap, works out
// each expected speed report on its own and compares every popped report
// field by field against the oldest one still due.
// ============================================================================

module speed_trap_compare
    import stu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  in_item_t           item,
    input  logic               pop,
    input  logic               empty,
    input  out_item_t          result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [DIST_W-1:0]  cfg_data,
    output int unsigned        mismatches,
    output int unsigned        pending,
    output int unsigned        reports_checked
);

    // Speed in 1/256 km/h is distance * 3.6 * 256 / elapsed.
    localparam logic [63:0] KMH_Q8_NUM = 64'd9216;
    localparam logic [63:0] KMH_Q8_DEN = 64'd10;

    logic [DIST_W-1:0] distance_mm;
    logic              armed;
    logic [TIME_W-1:0] arm_time;
    logic [TIME_W-1:0] success_total;
    out_item_t         reports_due[$];

    initial
    begin
        mismatches      = 0;
        pending         = 0;
        reports_checked = 0;
    end

    // Applies one accepted gate request to the shadow state and queues the
    // speed report that it causes, if any.
    task automatic take_gate_request(input in_item_t req);
        logic [TIME_W-1:0] dt;
        logic [63:0]       quotient;
        out_item_t         report;
        if (req.first_gate_edge && !armed)
        begin
            armed    = 1'b1;
            arm_time = req.now_ms;
        end
        if (req.second_gate_edge && armed)
        begin
            armed             = 1'b0;
            dt                = req.now_ms - arm_time;
            report.elapsed_ms = dt;
            if (dt == '0)
            begin
                report.status   = STATUS_RANGE_ERR;
                report.speed_q8 = '0;
            end
            else
            begin
                quotient        = (64'(distance_mm) * KMH_Q8_NUM) / (64'(dt) * KMH_Q8_DEN);
                report.speed_q8 = quotient[SPEED_W-1:0];
                report.status   = STATUS_OK;
                success_total   = success_total + 1'b1;
            end
            report.event_number = success_total;
            reports_due.push_back(report);
        end
    endtask

    task automatic check_report(input out_item_t got);
        out_item_t want;
        logic      bad;
        reports_checked++;
        if (reports_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: speed report with none due: speed_q8=%0d status=%0d event=%0d elapsed=%0d",
                         $realtime, got.speed_q8, got.status, got.event_number, got.elapsed_ms);
        end
        else
        begin
            want = reports_due.pop_front();
            bad  = 1'b0;
            if (got.speed_q8 !== want.speed_q8)
                bad = 1'b1;
            if (got.status !== want.status)
                bad = 1'b1;
            if (got.event_number !== want.event_number)
                bad = 1'b1;
            if (got.elapsed_ms !== want.elapsed_ms)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: speed report mismatch", $realtime);
                    $display("    expected speed_q8=%0d status=%0d event=%0d elapsed=%0d",
                             want.speed_q8, want.status, want.event_number, want.elapsed_ms);
                    $display("    actual   speed_q8=%0d status=%0d event=%0d elapsed=%0d",
                             got.speed_q8, got.status, got.event_number, got.elapsed_ms);
                end
            end
        end
    endtask

    // A report popped at the same edge as a new gate request is always an
    // older one, so it is checked before the request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_mm   = DIST_RESET;
            armed         = 1'b0;
            arm_time      = '0;
            success_total = '0;
            reports_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                distance_mm = cfg_data;
            if (pop && !empty)
                check_report(result);
            if (push && !full)
                take_gate_request(item);
        end
        pending = reports_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Stimulus and verdict for the two-gate speed trap.
// ============================================================================
//
// The block is driven with gate requests from a bursty sender while the result
// side pops on a stall pattern of its own. A directed opening walks through the
// corner cases of arming and firing; then a series of distance settings, the
// extremes among them, each get at least 180 requests of mostly well-formed
// measurements (first-gate edge, some filler, second-gate edge) mixed with random
// noise. The compare module beside the block predicts every report and counts mismatches.
//

module testbench;

    import stu_pkg::*;

    localparam int PHASES           = 8;
    localparam int PHASE_REQUESTS   = 180;
    // Leave a margin for the divider to finish before touching the distance.
    localparam int SETTLE_CYCLES    = 48;
    localparam int DRAIN_LIMIT      = 100000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    in_item_t          item      = '0;
    logic              pop       = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [DIST_W-1:0] cfg_data  = '0;
    logic              full;
    logic              empty;
    logic              cfg_ready;
    out_item_t         result;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned reports_checked;

    int unsigned requests_sent = 0;
    int unsigned burst_left    = 0;
    int unsigned pop_mode      = 0;
    int unsigned pop_mode_left = 0;
    int unsigned drain_wait;

    logic [DIST_W-1:0] distances[PHASES];

    two_gate_speed_trap_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    speed_trap_compare compare_u (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .pop             (pop),
        .empty           (empty),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .reports_checked (reports_checked)
    );

    // 4 ns period.
    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // The result side switches between popping every cycle, popping at random
    // and long stalls, each mode held for a random stretch.
    always @(posedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode      = $urandom_range(0, 2);
            pop_mode_left = $urandom_range(20, 300);
        end
        else
            pop_mode_left--;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Sends one gate request and returns once it is taken and any gap after it
    // is over. Push stays high into the next request unless a gap follows.
    task automatic send_gate(input logic [TIME_W-1:0] now, input logic first_edge,
                             input logic second_edge, input bit counted);
        push                  <= 1'b1;
        item.now_ms           <= now;
        item.first_gate_edge  <= first_edge;
        item.second_gate_edge <= second_edge;
        do
            @(posedge clk);
        while (full);
        if (counted)
            requests_sent++;
        // Bursts of random length with random gaps; some bursts are long so
        // that stretches without any idling occur too.
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    // Waits until every report due has been popped and the divider has had
    // time to finish, so that a distance write cannot race a measurement.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_distance(input logic [DIST_W-1:0] mm);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mm;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One well-formed measurement: a first-gate edge, a little filler, then a
    // second-gate edge after an elapsed time drawn from several ranges.
    task automatic run_measurement();
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] dt;
        case ($urandom_range(0, 9))
            0:       t0 = '0;
            1:       t0 = 32'hFFFF_FFFF - $urandom_range(0, 50);
            default: t0 = $urandom();
        endcase
        case ($urandom_range(0, 9))
            0:         dt = '0;
            1:         dt = 32'd1;
            2:         dt = 32'hFFFF_FFFF;
            3, 4, 5:   dt = $urandom_range(2, 2000);
            6, 7:      dt = $urandom_range(2001, 5000000);
            default:   dt = $urandom();
        endcase
        // Now and then both edges come together, which fires at once.
        send_gate(t0, 1'b1, ($urandom_range(0, 19) == 0), 1'b1);
        repeat ($urandom_range(0, 2))
            send_gate(t0 + $urandom_range(0, 3), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
        send_gate(t0 + dt, ($urandom_range(0, 3) == 0), 1'b1, 1'b1);
    endtask

    initial
    begin
        distances[0] = 16'hFFFF;
        distances[1] = 16'd1;
        distances[2] = 16'd0;       // out of range, but the block takes it
        distances[3] = 16'($urandom_range(1, 65535));
        distances[4] = 16'd1000;
        distances[5] = 16'($urandom_range(1, 255));
        distances[6] = 16'($urandom_range(256, 65535));
        distances[7] = 16'hFFFF;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset distance of 1000 mm.
        send_gate(32'd0, 1'b0, 1'b1, 1'b1);           // second-gate edge, idle: no report
        send_gate(32'd0, 1'b1, 1'b0, 1'b1);           // arm at time zero
        send_gate(32'd5, 1'b1, 1'b0, 1'b1);           // re-arm is ignored, keeps time zero
        send_gate(32'd3, 1'b0, 1'b0, 1'b1);           // no edges at all
        send_gate(32'd1, 1'b0, 1'b1, 1'b1);           // one millisecond: fastest speed
        send_gate(32'd100, 1'b1, 1'b1, 1'b1);         // both edges while idle: range error
        send_gate(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1);
        send_gate(32'd16, 1'b0, 1'b1, 1'b1);          // time wraps between the gates
        send_gate(32'd7, 1'b1, 1'b0, 1'b1);
        send_gate(32'd6, 1'b0, 1'b1, 1'b1);           // largest elapsed time
        send_gate(32'd50, 1'b1, 1'b0, 1'b1);
        send_gate(32'd60, 1'b1, 1'b1, 1'b1);          // both edges while armed
        send_gate(32'd200, 1'b1, 1'b0, 1'b1);
        send_gate(32'd200, 1'b0, 1'b1, 1'b1);         // same time on both gates
        send_gate(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        send_gate(32'd999, 1'b0, 1'b1, 1'b1);
        send_gate(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);   // idle again, ignored

        // Random measurements under each distance setting. About one draw in
        // five sends a single noise request with every field random instead.
        for (int p = 0; p < PHASES; p++)
        begin
            set_distance(distances[p]);
            for (int unsigned start = requests_sent; requests_sent - start < PHASE_REQUESTS; )
            begin
                if ($urandom_range(0, 99) < 80)
                    run_measurement();
                else
                    send_gate($urandom(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b1);
            end
        end

        push <= 1'b0;
        drain_wait = 0;
        @(posedge clk);
        while (pending != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        // Give a stray late report the chance to show up.
        repeat (64) @(posedge clk);

        $display("Sent %0d gate requests under %0d distance settings after the reset one.",
                 requests_sent, PHASES);
        $display("Checked %0d speed reports, %0d mismatches, %0d reports never arrived.",
                 reports_checked, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard limit far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("Timeout with %0d speed reports still due.", pending);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stu_pkg.sv
hw/rtl/stu_front.sv
hw/rtl/stu_queue.sv
hw/rtl/stu_back.sv
hw/rtl/two_gate_speed_trap_unit.sv
hw/rtl/stu_checker.sv
tb/sv/speed_trap_compare.sv
tb/sv/testbench.sv
